### design/iiea_pkg.sv
// Shared types and constants for the indexed insert/erase array.
// Used by iiea_cell, iiea_gather, indexed_insert_erase_array_core and the testbench.
// No dependencies.
package iiea_pkg;

    localparam int FUNC_W       = 2;
    localparam int POS_W        = 7;
    localparam int IN_VALUE_W   = 32;
    localparam int READ_W       = 32;
    localparam int COUNT_W      = 7;
    localparam int STATUS_W     = 2;
    localparam int S_TDATA_W    = 48;
    localparam int M_TDATA_W    = 48;

    localparam int DEFAULT_CAPACITY   = 64;
    localparam int DEFAULT_DATA_WIDTH = 32;
    localparam int GATHER_GROUP       = 8;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_ERASE  = 2'd1,
        FUNC_READ   = 2'd2,
        FUNC_WRITE  = 2'd3
    } iiea_func_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_EMPTY = 2'd3
    } iiea_status_t;

    // Command broadcast to every cell; at most one of ins/del/wr/rd is set.
    typedef struct packed {
        logic             ins;
        logic             del;
        logic             wr;
        logic             rd;
        logic [POS_W-1:0] position;
    } iiea_cmd_t;

endpackage

### design/indexed_insert_erase_array_core.sv
// Ordered array of CAPACITY entries with indexed insert, erase, read and overwrite.
// Each request passes through capture, one update of the cell row (every cell
// shifts, loads or holds at once, and the read taps land in the first OR level),
// and the final OR level into the output register.
// The next request is taken while a result still waits on m_.
// Refused requests change nothing and report a nonzero status.
// Depends on iiea_pkg, iiea_cell and iiea_gather.
module indexed_insert_erase_array_core import iiea_pkg::*; #(
    parameter int CAPACITY   = DEFAULT_CAPACITY,
    parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [1:0] func, [8:2] position, [40:9] item_value, [47:41] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [31:0] read_value, [38:32] element_count, [40:39] status, [47:41] zero
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_GATHER
    } state_t;

    state_t                state_reg;
    iiea_func_t            func_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [DATA_WIDTH-1:0] value_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    iiea_status_t          status_reg;
    iiea_status_t          status_next;
    logic                  m_tvalid_reg;
    logic [READ_W-1:0]     m_read_reg;
    logic [COUNT_W-1:0]    m_count_reg;
    iiea_status_t          m_status_reg;

    logic [CMP_W-1:0]      pos_ext;
    logic [CMP_W-1:0]      cnt_ext;
    iiea_cmd_t             cell_cmd;
    logic                  exec;
    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
    logic [DATA_WIDTH-1:0] cell_tap  [CAPACITY];
    logic [DATA_WIDTH-1:0] gather_data;

    assign exec    = (state_reg == ST_EXEC);
    assign pos_ext = CMP_W'(pos_reg);
    assign cnt_ext = CMP_W'(count_reg);

    always_comb begin
        status_next = STAT_OK;
        count_next  = count_reg;
        case (func_reg)
            FUNC_INSERT: begin
                if (cnt_ext == CAP_C) begin
                    status_next = STAT_FULL;
                end else if (pos_ext > cnt_ext) begin
                    status_next = STAT_RANGE;
                end else begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            FUNC_ERASE: begin
                if (count_reg == '0) begin
                    status_next = STAT_EMPTY;
                end else if (pos_ext >= cnt_ext) begin
                    status_next = STAT_RANGE;
                end else begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            FUNC_READ, FUNC_WRITE: begin
                if (pos_ext >= cnt_ext) begin
                    status_next = STAT_RANGE;
                end
            end
            default: begin
                status_next = STAT_RANGE;
            end
        endcase
    end

    always_comb begin
        cell_cmd.ins      = exec && (status_next == STAT_OK) && (func_reg == FUNC_INSERT);
        cell_cmd.del      = exec && (status_next == STAT_OK) && (func_reg == FUNC_ERASE);
        cell_cmd.wr       = exec && (status_next == STAT_OK) && (func_reg == FUNC_WRITE);
        cell_cmd.rd       = exec && (status_next == STAT_OK) && (func_reg == FUNC_READ);
        cell_cmd.position = pos_reg;
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DATA_WIDTH-1:0] left_data;
        logic [DATA_WIDTH-1:0] right_data;

        if (i == 0) begin : g_first
            assign left_data = '0;
        end else begin : g_mid_l
            assign left_data = cell_data[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_data = cell_data[i];
        end else begin : g_mid_r
            assign right_data = cell_data[i+1];
        end

        iiea_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CMP_W      (CMP_W),
            .INDEX      (i)
        ) u_cell (
            .aclk    (aclk),
            .cmd_i   (cell_cmd),
            .value_i (value_reg),
            .left_i  (left_data),
            .right_i (right_data),
            .data_o  (cell_data[i]),
            .tap_o   (cell_tap[i])
        );
    end

    iiea_gather #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_gather (
        .aclk   (aclk),
        .en_i   (exec),
        .taps_i (cell_tap),
        .data_o (gather_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && state_reg != ST_GATHER) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        func_reg  <= iiea_func_t'(s_tdata[1:0]);
                        pos_reg   <= s_tdata[8:2];
                        value_reg <= DATA_WIDTH'(s_tdata[40:9]);
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    count_reg  <= count_next;
                    status_reg <= status_next;
                    state_reg  <= ST_GATHER;
                end
                ST_GATHER: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_read_reg   <= READ_W'(gather_data);
                        m_count_reg  <= COUNT_W'(count_reg);
                        m_status_reg <= status_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, m_status_reg, m_count_reg, m_read_reg};

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CMP_W'(count_reg) <= CAP_C)
        else $error("element count above capacity");

    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cell_cmd.ins, cell_cmd.del, cell_cmd.wr, cell_cmd.rd}))
        else $error("more than one cell command at once");

    a_insert_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cell_cmd.ins |=> count_reg == CNT_W'($past(count_reg) + CNT_W'(1)))
        else $error("insert did not advance the count");

    a_erase_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cell_cmd.del |=> count_reg == CNT_W'($past(count_reg) - CNT_W'(1)))
        else $error("erase did not drop the count");

    a_refused_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_status_reg != STAT_OK) |-> m_read_reg == '0)
        else $error("refused request returned read data");
`endif

endmodule

### design/iiea_cell.sv
// One element cell of the array row: holds one entry, shifts with its neighbors.
// Depends on iiea_pkg.
module iiea_cell import iiea_pkg::*; #(
    parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH,
    parameter int CMP_W      = 8,
    parameter int INDEX      = 0
) (
    input  logic                  aclk,
    input  iiea_cmd_t             cmd_i,
    input  logic [DATA_WIDTH-1:0] value_i,
    input  logic [DATA_WIDTH-1:0] left_i,
    input  logic [DATA_WIDTH-1:0] right_i,
    output logic [DATA_WIDTH-1:0] data_o,
    output logic [DATA_WIDTH-1:0] tap_o
);

    localparam logic [CMP_W-1:0] IDX = CMP_W'(INDEX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic [CMP_W-1:0]      pos_ext;
    logic                  hit;
    logic                  above;

    assign pos_ext = CMP_W'(cmd_i.position);
    assign hit     = (pos_ext == IDX);
    assign above   = (IDX > pos_ext);

    always_comb begin
        data_next = data_reg;
        if (cmd_i.ins) begin
            if (hit) begin
                data_next = value_i;
            end else if (above) begin
                data_next = left_i;
            end
        end else if (cmd_i.del) begin
            if (hit || above) begin
                data_next = right_i;
            end
        end else if (cmd_i.wr && hit) begin
            data_next = value_i;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_o = data_reg;
    assign tap_o  = (cmd_i.rd && hit) ? data_reg : '0;

endmodule

### design/iiea_gather.sv
// Two-level OR tree that collects the read tap of the cell row.
// Depends on iiea_pkg.
module iiea_gather import iiea_pkg::*; #(
    parameter int CAPACITY   = DEFAULT_CAPACITY,
    parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH
) (
    input  logic                  aclk,
    input  logic                  en_i,
    input  logic [DATA_WIDTH-1:0] taps_i [CAPACITY],
    output logic [DATA_WIDTH-1:0] data_o
);

    localparam int NGROUP = (CAPACITY + GATHER_GROUP - 1) / GATHER_GROUP;

    logic [DATA_WIDTH-1:0] group_reg  [NGROUP];
    logic [DATA_WIDTH-1:0] group_next [NGROUP];

    always_comb begin
        for (int g = 0; g < NGROUP; g++) begin
            group_next[g] = '0;
            for (int k = 0; k < GATHER_GROUP; k++) begin
                if (g * GATHER_GROUP + k < CAPACITY) begin
                    group_next[g] = group_next[g] | taps_i[g * GATHER_GROUP + k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en_i) begin
            for (int g = 0; g < NGROUP; g++) begin
                group_reg[g] <= group_next[g];
            end
        end
    end

    always_comb begin
        data_o = '0;
        for (int g = 0; g < NGROUP; g++) begin
            data_o = data_o | group_reg[g];
        end
    end

endmodule

### tb/sv/indexed_insert_erase_array_checker.sv
// Checker for indexed_insert_erase_array_core: watches both stream channels, keeps its own
// copy of the array and count, and compares every accepted result field by field.
// Depends on iiea_pkg.
`timescale 1ns / 1ps

module indexed_insert_erase_array_checker import iiea_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    // [1:0] func, [8:2] position, [40:9] item_value, [47:41] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    // [31:0] read_value, [38:32] element_count, [40:39] status, [47:41] zero
    input  logic [M_TDATA_W-1:0] m_tdata,
    output int                   replies_due,
    output int                   mismatches
);

    typedef struct packed {
        logic [READ_W-1:0]  value;
        logic [COUNT_W-1:0] count;
        iiea_status_t       status;
    } array_reply_t;

    logic [DEFAULT_DATA_WIDTH-1:0] shadow_cells [DEFAULT_CAPACITY];
    int                            shadow_count = 0;
    array_reply_t                  expected_replies[$];
    array_reply_t                  want;
    int                            error_tally = 0;

    function automatic array_reply_t apply_array_op(input iiea_func_t op,
                                                    input logic [POS_W-1:0] position,
                                                    input logic [IN_VALUE_W-1:0] value);
        array_reply_t r;
        int           p;
        r.value  = '0;
        r.status = STAT_OK;
        p        = int'(position);
        case (op)
            FUNC_INSERT: begin
                if (shadow_count >= DEFAULT_CAPACITY) begin
                    r.status = STAT_FULL;
                end else if (p > shadow_count) begin
                    r.status = STAT_RANGE;
                end else begin
                    for (int i = shadow_count; i > p; i--)
                        shadow_cells[i] = shadow_cells[i-1];
                    shadow_cells[p] = value[DEFAULT_DATA_WIDTH-1:0];
                    shadow_count++;
                end
            end
            FUNC_ERASE: begin
                if (shadow_count == 0) begin
                    r.status = STAT_EMPTY;
                end else if (p >= shadow_count) begin
                    r.status = STAT_RANGE;
                end else begin
                    for (int i = p; i + 1 < shadow_count; i++)
                        shadow_cells[i] = shadow_cells[i+1];
                    shadow_count--;
                end
            end
            FUNC_READ: begin
                if (p >= shadow_count)
                    r.status = STAT_RANGE;
                else
                    r.value = READ_W'(shadow_cells[p]);
            end
            default: begin
                if (p >= shadow_count)
                    r.status = STAT_RANGE;
                else
                    shadow_cells[p] = value[DEFAULT_DATA_WIDTH-1:0];
            end
        endcase
        r.count = COUNT_W'(shadow_count);
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            shadow_count = 0;
            expected_replies.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_replies.size() == 0) begin
                    $display("%0t ns: result with no request pending: expected none, actual %h",
                             $time, m_tdata);
                    error_tally++;
                end else begin
                    want = expected_replies.pop_front();
                    if (m_tdata[READ_W-1:0] !== want.value) begin
                        $display("%0t ns: read_value mismatch: expected %h, actual %h",
                                 $time, want.value, m_tdata[READ_W-1:0]);
                        error_tally++;
                    end
                    if (m_tdata[READ_W +: COUNT_W] !== want.count) begin
                        $display("%0t ns: element_count mismatch: expected %0d, actual %0d",
                                 $time, want.count, m_tdata[READ_W +: COUNT_W]);
                        error_tally++;
                    end
                    if (m_tdata[READ_W+COUNT_W +: STATUS_W] !== want.status) begin
                        $display("%0t ns: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, m_tdata[READ_W+COUNT_W +: STATUS_W]);
                        error_tally++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_replies.push_back(apply_array_op(
                    iiea_func_t'(s_tdata[FUNC_W-1:0]),
                    s_tdata[FUNC_W +: POS_W],
                    s_tdata[FUNC_W+POS_W +: IN_VALUE_W]));
        end
        replies_due <= expected_replies.size();
        mismatches  <= error_tally;
    end

endmodule

### tb/sv/indexed_insert_erase_array_core_test.sv
// Top of the indexed_insert_erase_array_core testbench: clock, reset, request stimulus and
// result-side back-pressure, plus the final verdict.
// Depends on iiea_pkg, the core and indexed_insert_erase_array_checker.
`timescale 1ns / 1ps

module indexed_insert_erase_array_core_test;
    import iiea_pkg::*;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // [1:0] func, [8:2] position, [40:9] item_value, [47:41] zero
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // [31:0] read_value, [38:32] element_count, [40:39] status, [47:41] zero
    logic [M_TDATA_W-1:0] m_tdata;

    int replies_due;
    int mismatches;
    int fill_level = 0;
    bit calm       = 1'b0;
    bit long_hold  = 1'b0;

    always #2 aclk = ~aclk;

    indexed_insert_erase_array_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    indexed_insert_erase_array_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .replies_due (replies_due),
        .mismatches  (mismatches)
    );

    task automatic offer_request(input iiea_func_t op, input int position,
                                 input logic [IN_VALUE_W-1:0] value);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({value, POS_W'(position), op});
        do @(posedge aclk); while (!s_tready);
        case (op)
            FUNC_INSERT: if (fill_level < DEFAULT_CAPACITY && position <= fill_level) fill_level++;
            FUNC_ERASE:  if (fill_level > 0 && position < fill_level) fill_level--;
            default: ;
        endcase
    endtask

    function automatic int pick_position(input iiea_func_t op);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return $urandom_range(0, 127);
        if (sel == 1)
            return fill_level;
        if (op == FUNC_INSERT)
            return $urandom_range(0, fill_level);
        return (fill_level == 0) ? 0 : $urandom_range(0, fill_level - 1);
    endfunction

    function automatic logic [IN_VALUE_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return '1;
        return $urandom;
    endfunction

    function automatic iiea_func_t pick_func(input int phase);
        int r;
        r = $urandom_range(0, 99);
        if (phase == 0) begin
            if (r < 80) return FUNC_INSERT;
            if (r < 85) return FUNC_ERASE;
        end else if (phase == 2) begin
            if (r < 80) return FUNC_ERASE;
            if (r < 85) return FUNC_INSERT;
        end else begin
            if (r < 25) return FUNC_INSERT;
            if (r < 50) return FUNC_ERASE;
        end
        return (r % 2 == 0) ? FUNC_READ : FUNC_WRITE;
    endfunction

    initial begin
        iiea_func_t op;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        offer_request(FUNC_READ,   0,   32'h0000_0000);
        offer_request(FUNC_WRITE,  0,   32'hFFFF_FFFF);
        offer_request(FUNC_ERASE,  0,   32'h0000_0000);
        offer_request(FUNC_ERASE,  127, 32'h0000_0000);
        offer_request(FUNC_INSERT, 1,   32'h1111_1111);
        offer_request(FUNC_INSERT, 0,   32'hFFFF_FFFF);
        offer_request(FUNC_INSERT, 1,   32'h0000_0000);
        offer_request(FUNC_INSERT, 0,   32'hA5A5_5A5A);
        offer_request(FUNC_INSERT, 1,   32'h1234_5678);
        for (int i = 0; i < 4; i++)
            offer_request(FUNC_READ, i, 32'hFFFF_FFFF);
        offer_request(FUNC_READ,   4,   32'h0000_0000);
        offer_request(FUNC_READ,   127, 32'h0000_0000);
        offer_request(FUNC_WRITE,  3,   32'h5555_AAAA);
        offer_request(FUNC_READ,   3,   32'h0000_0000);
        offer_request(FUNC_WRITE,  4,   32'hDEAD_BEEF);
        offer_request(FUNC_INSERT, 127, 32'hFFFF_FFFF);
        offer_request(FUNC_INSERT, 5,   32'h0F0F_0F0F);
        offer_request(FUNC_ERASE,  1,   32'h0000_0000);
        offer_request(FUNC_ERASE,  2,   32'h0000_0000);
        offer_request(FUNC_ERASE,  2,   32'h0000_0000);
        offer_request(FUNC_READ,   0,   32'h0000_0000);
        offer_request(FUNC_READ,   1,   32'h0000_0000);

        for (int n = 0; n < 600; n++) begin
            if (n == 150)
                long_hold = 1'b1;
            if (n == 330) begin
                s_tvalid <= 1'b0;
                do @(posedge aclk); while (replies_due != 0);
            end
            if (n == 520)
                calm = 1'b1;
            op = pick_func((n / 70) % 3);
            offer_request(op, pick_position(op), pick_value());
        end

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (replies_due != 0);
        repeat (12) @(posedge aclk);
        if (mismatches == 0)
            $display("indexed_insert_erase_array_core regression: pass");
        else
            $display("indexed_insert_erase_array_core regression: fail");
        $finish;
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (long_hold) begin
                m_tready <= 1'b0;
                repeat (250) @(posedge aclk);
                long_hold = 1'b0;
                m_tready <= 1'b1;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #2_000_000;
        $display("indexed_insert_erase_array_core regression: fail");
        $finish;
    end

endmodule

### indexed_insert_erase_array_core.f
design/iiea_pkg.sv
design/iiea_cell.sv
design/iiea_gather.sv
design/indexed_insert_erase_array_core.sv
tb/sv/indexed_insert_erase_array_checker.sv
tb/sv/indexed_insert_erase_array_core_test.sv
